FILE: sv/grouped_bitmap_block_allocator_top_defines.svh
// Assertion macros for the block allocator.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define GBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/gba_pkg.sv
`default_nettype none
package gba_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic       ACT_ALLOC  = 1'b0;
    localparam logic       ACT_FREE   = 1'b1;
    localparam logic [1:0] REG_FIRST  = 2'd0;
    localparam logic [1:0] REG_BPG    = 2'd1;
    localparam logic [1:0] REG_GROUPS = 2'd2;
    localparam logic [1:0] REG_TOTAL  = 2'd3;
    localparam int GROUP_CNT_MAX = 2047;
    localparam int TOTAL_CNT_MAX = 32767;
endpackage
`default_nettype wire

FILE: sv/grouped_bitmap_block_allocator_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata: action, start_group, block_in
// m_axis    out        tdata: status, block_out, free_total
// cfg       in         index (2 bits), data (15 bits)
//
// An allocate passes from the accept cycle through hint reduction by compare and subtract,
// the group scan and, for each 64-bit bitmap word it reads (up to 16 words), the read,
// wait and check states. A free passes from the accept cycle through a bit-serial divide
// and a read-modify-write of the bitmap word.
// After reset and after a geometry write, a clearing pass holds s_tready low.
// The result sits in an output register; a stalled m_tready holds the block in its done state.
`default_nettype none
`include "grouped_bitmap_block_allocator_top_defines.svh"
module grouped_bitmap_block_allocator_top #(
    parameter int MAX_GROUPS           = 16,
    parameter int BLOCKS_PER_GROUP_MAX = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // action[0], start_group[16:1], block_in[48:17]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // status[1:0], block_out[16:2], free_total[31:17]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    import gba_pkg::*;

    localparam int WPG    = (BLOCKS_PER_GROUP_MAX + 63) / 64;
    localparam int WORDS  = (MAX_GROUPS * BLOCKS_PER_GROUP_MAX + 63) / 64;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW    = $clog2(MAX_GROUPS + 1);
    localparam int BW     = $clog2(BLOCKS_PER_GROUP_MAX + 1);
    localparam int WW     = (WPG > 1) ? $clog2(WPG) : 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HMOD  = 4'd2;
    localparam logic [3:0] S_GSCAN = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_WAIT  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FRD   = 4'd8;
    localparam logic [3:0] S_FWAIT = 4'd9;
    localparam logic [3:0] S_FWR   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]  state_reg;
    logic        fdb_reg;
    logic [10:0] bpg_reg;
    logic [4:0]  gc_reg;
    logic [14:0] tb_reg;
    logic [10:0] gfree_reg [MAX_GROUPS];
    logic [14:0] tfree_reg;
    logic [AW-1:0] clr_reg;
    logic        fmt_reg;

    logic [16:0] acc_reg;     // hint remainder / divide remainder
    logic [31:0] quo_reg;     // divide dividend shifting to quotient
    logic [4:0]  cnt_reg;
    logic [GW-1:0] grp_reg;
    logic [WW-1:0] wrd_reg;
    logic [1:0]  st_reg;
    logic [14:0] bo_reg;
    logic [9:0]  bit_reg;
    logic        free_reg;

    // Effective geometry.
    logic [BW-1:0]  bpg_eff;
    logic [GCW-1:0] ng_eff;
    always_comb begin
        if (bpg_reg == '0) bpg_eff = BW'(1);
        else if ({21'd0, bpg_reg} > BLOCKS_PER_GROUP_MAX) bpg_eff = BW'(BLOCKS_PER_GROUP_MAX);
        else bpg_eff = BW'(bpg_reg);
        if (gc_reg == '0) ng_eff = GCW'(1);
        else if ({27'd0, gc_reg} > MAX_GROUPS) ng_eff = GCW'(MAX_GROUPS);
        else ng_eff = GCW'(gc_reg);
    end

    logic [10:0] fmt_gfree;
    logic [14:0] fmt_total;
    logic [31:0] fmt_prod;
    assign fmt_prod  = 32'(ng_eff) * 32'(bpg_eff);
    assign fmt_gfree = (32'(bpg_eff) > GROUP_CNT_MAX) ? 11'(GROUP_CNT_MAX) : 11'(bpg_eff);
    assign fmt_total = (fmt_prod > 32'(TOTAL_CNT_MAX)) ? 15'(TOTAL_CNT_MAX) : fmt_prod[14:0];

    // Bitmap RAM.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    gba_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic [AW-1:0] word_addr;
    assign word_addr = AW'(32'(grp_reg) * 32'(WPG) + 32'(wrd_reg));
    assign ram_raddr = word_addr;

    // Word scan: lowest clear bit in the current word, limited to bpg.
    logic [63:0] inv_w;
    logic [5:0]  low_idx;
    logic        low_any;
    logic [15:0] bit_abs;
    always_comb begin
        inv_w = ~ram_rdata;
        low_idx = '0;
        low_any = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (inv_w[i]) begin
                low_idx = 6'(i);
                low_any = 1'b1;
            end
        end
        bit_abs = 16'({wrd_reg, 6'd0}) + 16'(low_idx);
    end

    // Divide step: shift one dividend bit into the remainder.
    logic [16:0] div_try;
    assign div_try = {acc_reg[15:0], quo_reg[31]};
    // Hint reduction step: the shifted group count is kept wide enough that the
    // compare is exact at every shift.
    logic [21:0] hint_shift;
    logic [16:0] hint_sub;
    assign hint_shift = 22'(ng_eff) << cnt_reg[3:0];
    assign hint_sub   = acc_reg - hint_shift[16:0];

    logic [31:0] rel_blk;
    assign rel_blk = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            fdb_reg   <= 1'b0;
            bpg_reg   <= 11'd1024;
            gc_reg    <= 5'd16;
            tb_reg    <= 15'd16384;
            clr_reg   <= '0;
            fmt_reg   <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FIRST:  fdb_reg <= cfg_data[0];
                    REG_BPG: begin
                        bpg_reg <= cfg_data[10:0];
                        fmt_reg <= 1'b1;
                        clr_reg <= '0;
                        state_reg <= S_CLEAR;
                    end
                    REG_GROUPS: begin
                        gc_reg <= cfg_data[4:0];
                        fmt_reg <= 1'b1;
                        clr_reg <= '0;
                        state_reg <= S_CLEAR;
                    end
                    REG_TOTAL:  tb_reg <= cfg_data;
                    default: ;
                endcase
            end else begin
                case (state_reg)
                    S_CLEAR: begin
                        if (fmt_reg) begin
                            for (int g = 0; g < MAX_GROUPS; g++) gfree_reg[g] <= fmt_gfree;
                            tfree_reg <= fmt_total;
                            fmt_reg   <= 1'b0;
                        end
                        clr_reg <= clr_reg + AW'(1);
                        if (32'(clr_reg) == WORDS - 1) state_reg <= S_IDLE;
                    end
                    S_IDLE: begin
                        if (s_tvalid) begin
                            bo_reg <= '0;
                            if (s_tdata[0] == ACT_ALLOC) begin
                                if (tfree_reg == '0) begin
                                    st_reg <= ST_NOSPACE;
                                    state_reg <= S_DONE;
                                end else begin
                                    st_reg <= ST_OK;
                                    acc_reg <= {1'b0, s_tdata[16:1]};
                                    cnt_reg <= 5'd15;
                                    state_reg <= S_HMOD;
                                end
                            end else begin
                                if (s_tdata[48:17] < 32'(fdb_reg) ||
                                    s_tdata[48:17] >= 32'(tb_reg)) begin
                                    st_reg <= ST_INVALID;
                                    state_reg <= S_DONE;
                                end else begin
                                    st_reg <= ST_OK;
                                    quo_reg <= s_tdata[48:17] - 32'(fdb_reg);
                                    acc_reg <= '0;
                                    cnt_reg <= 5'd31;
                                    state_reg <= S_DIV;
                                end
                            end
                        end
                    end
                    S_HMOD: begin
                        // Restoring reduction of the hint modulo group count.
                        if ({5'd0, acc_reg} >= hint_shift) acc_reg <= hint_sub;
                        if (cnt_reg == '0) begin
                            cnt_reg <= '0;
                            state_reg <= S_GSCAN;
                        end else cnt_reg <= cnt_reg - 5'd1;
                    end
                    S_GSCAN: begin
                        if (cnt_reg == 5'd0) grp_reg <= GW'(acc_reg);
                        if (cnt_reg != 5'd0 && gfree_reg[grp_reg] != '0) begin
                            wrd_reg <= '0;
                            state_reg <= S_RD;
                        end else if (32'(cnt_reg) == 32'(ng_eff)) begin
                            st_reg <= ST_NOSPACE;
                            state_reg <= S_DONE;
                        end else begin
                            if (cnt_reg != 5'd0) begin
                                if (32'(grp_reg) + 1 >= 32'(ng_eff)) grp_reg <= '0;
                                else grp_reg <= grp_reg + GW'(1);
                            end
                            cnt_reg <= cnt_reg + 5'd1;
                        end
                    end
                    S_RD:   state_reg <= S_WAIT;
                    // A free passes through the shared wait state to the write.
                    S_WAIT: state_reg <= free_reg ? S_FWR : S_CHK;
                    S_CHK: begin
                        if (low_any && bit_abs < 16'(bpg_eff)) begin
                            bit_reg <= bit_abs[9:0];
                            bo_reg <= 15'(32'(fdb_reg) + 32'(grp_reg) * 32'(bpg_eff)
                                          + 32'(bit_abs));
                            gfree_reg[grp_reg] <= gfree_reg[grp_reg] - 11'd1;
                            tfree_reg <= tfree_reg - 15'd1;
                            state_reg <= S_DONE;
                        end else if (32'({16'(wrd_reg), 6'd0}) + 64 >= 32'(bpg_eff)) begin
                            st_reg <= ST_NOSPACE;
                            state_reg <= S_DONE;
                        end else begin
                            wrd_reg <= wrd_reg + WW'(1);
                            state_reg <= S_RD;
                        end
                    end
                    S_DIV: begin
                        if (div_try >= 17'(bpg_eff)) begin
                            acc_reg <= div_try - 17'(bpg_eff);
                            quo_reg <= {quo_reg[30:0], 1'b1};
                        end else begin
                            acc_reg <= div_try;
                            quo_reg <= {quo_reg[30:0], 1'b0};
                        end
                        if (cnt_reg == '0) state_reg <= S_FRD;
                        else cnt_reg <= cnt_reg - 5'd1;
                    end
                    S_FRD: begin
                        if (rel_blk >= 32'(ng_eff)) begin
                            st_reg <= ST_INVALID;
                            state_reg <= S_DONE;
                        end else begin
                            grp_reg <= GW'(rel_blk);
                            wrd_reg <= WW'(acc_reg[15:6]);
                            bit_reg <= acc_reg[9:0];
                            state_reg <= S_FWAIT;
                        end
                    end
                    S_FWAIT: state_reg <= S_WAIT;
                    S_FWR: begin
                        if (gfree_reg[grp_reg] != 11'(GROUP_CNT_MAX))
                            gfree_reg[grp_reg] <= gfree_reg[grp_reg] + 11'd1;
                        if (tfree_reg != 15'(TOTAL_CNT_MAX)) tfree_reg <= tfree_reg + 15'd1;
                        state_reg <= S_DONE;
                    end
                    S_DONE: if (m_tready) state_reg <= S_IDLE;
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    // Track whether the current item is a free, for the shared wait state.
    always_ff @(posedge aclk) begin
        if (!aresetn) free_reg <= 1'b0;
        else if (state_reg == S_IDLE && s_tvalid) free_reg <= s_tdata[0];
    end

    // Bitmap writes: clearing pass, set on allocate, clear on free.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = word_addr;
        ram_wdata = ram_rdata;
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (state_reg == S_CHK && !free_reg && low_any &&
                     bit_abs < 16'(bpg_eff)) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (64'd1 << low_idx);
        end else if (state_reg == S_FWR) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~(64'd1 << bit_reg[5:0]);
        end
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign m_tvalid  = (state_reg == S_DONE);
    assign m_tdata   = {tfree_reg, bo_reg, st_reg};

    `GBA_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `GBA_ASSERT_IMP(a_zero_on_fail, aclk, aresetn, m_tvalid && (st_reg != ST_OK), bo_reg == '0)
    `GBA_ASSERT_NEXT(a_done_hold, aclk, aresetn, m_tvalid && !m_tready && !cfg_valid, m_tvalid)
endmodule
`default_nettype wire

FILE: sv/gba_ram.sv
`default_nettype none
module gba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
